### design/arprr_pkg.sv
// ============================================================================
// ARP reply resolver package
// Shared types, codes and header offsets for the ARP reply resolver.
// ============================================================================
`default_nettype none

package arprr_pkg;

	// Header bytes that are collected for each frame.
	localparam int HEADER_BYTES = 42;
	localparam int POS_W        = 6;
	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(HEADER_BYTES);

	// Byte offsets of the checked fields within the frame.
	localparam int OFF_ETYPE = 12;
	localparam int OFF_HTYPE = 14;
	localparam int OFF_PTYPE = 16;
	localparam int OFF_OPER  = 20;
	localparam int OFF_SHA   = 22;
	localparam int OFF_SPA   = 28;
	localparam int OFF_TPA   = 38;

	// Expected field values.
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] HTYPE_ETH  = 16'h0001;
	localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
	localparam logic [15:0] OPER_REPLY = 16'h0002;

	// Input item modes.
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_BYTE  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Frame status codes.
	localparam logic [3:0] ST_MATCH        = 4'd0;
	localparam logic [3:0] ST_SHORT        = 4'd1;
	localparam logic [3:0] ST_NOT_ARP      = 4'd2;
	localparam logic [3:0] ST_NOT_ETH      = 4'd3;
	localparam logic [3:0] ST_NOT_IP       = 4'd4;
	localparam logic [3:0] ST_NOT_REPLY    = 4'd5;
	localparam logic [3:0] ST_SENDER_MISS  = 4'd6;
	localparam logic [3:0] ST_TARGET_MISS  = 4'd7;
	localparam logic [3:0] ST_NO_FRAME     = 4'd8;

	// Search phases.
	localparam logic [1:0] PH_SEARCH       = 2'd0;
	localparam logic [1:0] PH_RESOLVED     = 2'd1;
	localparam logic [1:0] PH_GAVE_TIMEOUT = 2'd2;
	localparam logic [1:0] PH_GAVE_FRAMES  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IP     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT   = 2'd3;

	localparam logic [7:0] LIMIT_RST = 8'd50;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data_byte;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  frame_status;
		logic [1:0]  search_state;
		logic [47:0] peer_mac;
	} out_item_t;

	typedef struct packed {
		logic [15:0] etype;
		logic [15:0] htype;
		logic [15:0] ptype;
		logic [15:0] oper;
		logic [47:0] sha;
		logic [31:0] spa;
		logic [31:0] tpa;
	} arp_hdr_t;

endpackage

`default_nettype wire

### design/arprr_check.sv
// ============================================================================
// ARP reply frame check
// Classifies a collected ARP header in priority order and gives its status.
// ============================================================================
`default_nettype none

module arprr_check (
	input  arprr_pkg::arp_hdr_t hdr,
	input  logic                complete,
	input  logic [31:0]         own_ip,
	input  logic [31:0]         target_ip,
	output logic [3:0]          status
);

	always_comb begin
		if (!complete) begin
			status = arprr_pkg::ST_SHORT;
		end else if (hdr.etype != arprr_pkg::ETYPE_ARP) begin
			status = arprr_pkg::ST_NOT_ARP;
		end else if (hdr.htype != arprr_pkg::HTYPE_ETH) begin
			status = arprr_pkg::ST_NOT_ETH;
		end else if (hdr.ptype != arprr_pkg::PTYPE_IPV4) begin
			status = arprr_pkg::ST_NOT_IP;
		end else if (hdr.oper != arprr_pkg::OPER_REPLY) begin
			status = arprr_pkg::ST_NOT_REPLY;
		end else if (hdr.spa != target_ip) begin
			status = arprr_pkg::ST_SENDER_MISS;
		end else if (hdr.tpa != own_ip) begin
			status = arprr_pkg::ST_TARGET_MISS;
		end else begin
			status = arprr_pkg::ST_MATCH;
		end
	end

endmodule

`default_nettype wire

### design/arp_reply_resolver_core.sv
// ============================================================================
// ARP reply resolver core
// Watches received frames for the ARP reply that resolves target_ip.
// ============================================================================
// Items enter on in_valid/in_stall: a start command, a frame byte, or a
// capture timeout tick. Every start, every tick and every frame byte marked
// last produces one result item on out_valid/out_stall carrying the frame
// status, the search state and the resolved MAC. Other bytes produce none.
// An accepted item sits in an input register, is processed by a single
// pass of compare logic, and its result lands in the output register.
// One item per cycle is sustained while the receiver keeps out_stall low.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; in_stall rises only once both
// are full. Configuration writes on cfg_valid/cfg_ready are always taken
// and must be done while no item is in flight.
// Reset clears the search (phase searching, counters and MAC zero), the
// frame position, both valid flags, and loads the default limits of 50
// with both IP addresses zero. Header bytes need no reset: a frame is only
// checked after all its header bytes were written.
// ============================================================================
`default_nettype none

module arp_reply_resolver_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  arprr_pkg::in_item_t                   in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output arprr_pkg::out_item_t                  out_item,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [arprr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                           cfg_data
);

	localparam int PW = arprr_pkg::POS_W;

	// Configuration registers.
	logic [31:0] own_ip_q;
	logic [31:0] target_ip_q;
	logic [7:0]  tlim_q;
	logic [7:0]  flim_q;

	// Input register.
	logic                valid_s1;
	arprr_pkg::in_item_t item_s1;

	// Search state.
	logic [PW-1:0] pos_q;
	logic [7:0]    tc_q;
	logic [7:0]    fc_q;
	logic [1:0]    phase_q;
	logic [47:0]   mac_q;
	arprr_pkg::arp_hdr_t hdr_q;

	// Output register.
	logic                 out_valid_q;
	arprr_pkg::out_item_t out_item_q;

	logic                out_free;
	logic                advance;
	logic                hdr_wr;
	logic [PW-1:0]       pos_inc;
	logic                complete;
	arprr_pkg::arp_hdr_t hdr_view;
	logic [3:0]          chk_status;

	logic [PW-1:0] pos_nx;
	logic [7:0]    tc_nx;
	logic [7:0]    fc_nx;
	logic [1:0]    phase_nx;
	logic [47:0]   mac_nx;
	logic [3:0]    status_nx;
	logic          has_result;
	logic [8:0]    fc_plus;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !out_free;
	assign advance   = valid_s1 && out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	assign hdr_wr  = advance && (item_s1.mode == arprr_pkg::MODE_BYTE) &&
		(pos_q < arprr_pkg::HDR_LEN);
	assign pos_inc = (pos_q < arprr_pkg::HDR_LEN) ? pos_q + PW'(1) : pos_q;
	assign complete = (pos_inc == arprr_pkg::HDR_LEN);

	// The final header byte may be the one arriving with last set.
	always_comb begin
		hdr_view = hdr_q;
		if (pos_q == PW'(arprr_pkg::OFF_TPA + 3)) begin
			hdr_view.tpa[7:0] = item_s1.data_byte;
		end
	end

	arprr_check u_check (
		.hdr       (hdr_view),
		.complete  (complete),
		.own_ip    (own_ip_q),
		.target_ip (target_ip_q),
		.status    (chk_status)
	);

	always_comb begin
		pos_nx     = pos_q;
		tc_nx      = tc_q;
		fc_nx      = fc_q;
		phase_nx   = phase_q;
		mac_nx     = mac_q;
		status_nx  = arprr_pkg::ST_NO_FRAME;
		has_result = 1'b0;
		fc_plus    = {1'b0, fc_q} + 9'd1;
		case (item_s1.mode)
			arprr_pkg::MODE_START: begin
				tc_nx      = 8'd0;
				fc_nx      = 8'd0;
				mac_nx     = 48'd0;
				phase_nx   = arprr_pkg::PH_SEARCH;
				has_result = 1'b1;
			end
			arprr_pkg::MODE_TICK: begin
				has_result = 1'b1;
				if (phase_q == arprr_pkg::PH_SEARCH) begin
					if (tc_q >= tlim_q) begin
						phase_nx = arprr_pkg::PH_GAVE_TIMEOUT;
					end else begin
						tc_nx = tc_q + 8'd1;
					end
				end
			end
			arprr_pkg::MODE_BYTE: begin
				pos_nx = pos_inc;
				if (item_s1.last) begin
					has_result = 1'b1;
					status_nx  = chk_status;
					pos_nx     = '0;
					if (phase_q == arprr_pkg::PH_SEARCH) begin
						if (chk_status == arprr_pkg::ST_MATCH) begin
							mac_nx   = hdr_view.sha;
							phase_nx = arprr_pkg::PH_RESOLVED;
						end else begin
							if (fc_plus >= {1'b0, flim_q}) begin
								phase_nx = arprr_pkg::PH_GAVE_FRAMES;
							end
							fc_nx = fc_plus[8] ? 8'hFF : fc_plus[7:0];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q    <= 32'd0;
			target_ip_q <= 32'd0;
			tlim_q      <= arprr_pkg::LIMIT_RST;
			flim_q      <= arprr_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				arprr_pkg::CFG_OWN_IP:        own_ip_q    <= cfg_data;
				arprr_pkg::CFG_TARGET_IP:     target_ip_q <= cfg_data;
				arprr_pkg::CFG_TIMEOUT_LIMIT: tlim_q      <= cfg_data[7:0];
				arprr_pkg::CFG_FRAME_LIMIT:   flim_q      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			tc_q        <= 8'd0;
			fc_q        <= 8'd0;
			phase_q     <= arprr_pkg::PH_SEARCH;
			mac_q       <= 48'd0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				out_valid_q <= advance && has_result;
			end
			if (advance) begin
				pos_q   <= pos_nx;
				tc_q    <= tc_nx;
				fc_q    <= fc_nx;
				phase_q <= phase_nx;
				mac_q   <= mac_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
		if (advance && has_result) begin
			out_item_q.frame_status <= status_nx;
			out_item_q.search_state <= phase_nx;
			out_item_q.peer_mac     <= mac_nx;
		end
	end

	// Header fields are captured at their fixed offsets.
	always_ff @(posedge clk) begin
		if (hdr_wr) begin
			case (pos_q)
				PW'(arprr_pkg::OFF_ETYPE):     hdr_q.etype[15:8] <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_ETYPE + 1): hdr_q.etype[7:0]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_HTYPE):     hdr_q.htype[15:8] <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_HTYPE + 1): hdr_q.htype[7:0]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_PTYPE):     hdr_q.ptype[15:8] <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_PTYPE + 1): hdr_q.ptype[7:0]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_OPER):      hdr_q.oper[15:8]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_OPER + 1):  hdr_q.oper[7:0]   <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA):       hdr_q.sha[47:40]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA + 1):   hdr_q.sha[39:32]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA + 2):   hdr_q.sha[31:24]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA + 3):   hdr_q.sha[23:16]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA + 4):   hdr_q.sha[15:8]   <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SHA + 5):   hdr_q.sha[7:0]    <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SPA):       hdr_q.spa[31:24]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SPA + 1):   hdr_q.spa[23:16]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SPA + 2):   hdr_q.spa[15:8]   <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_SPA + 3):   hdr_q.spa[7:0]    <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_TPA):       hdr_q.tpa[31:24]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_TPA + 1):   hdr_q.tpa[23:16]  <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_TPA + 2):   hdr_q.tpa[15:8]   <= item_s1.data_byte;
				PW'(arprr_pkg::OFF_TPA + 3):   hdr_q.tpa[7:0]    <= item_s1.data_byte;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### design/arprr_checker.sv
// ============================================================================
// ARP reply resolver port checker
// Watches the top-level ports of the resolver for protocol and state slips.
// ============================================================================
`default_nettype none

module arprr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input arprr_pkg::out_item_t            out_item
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_item))
		else $error("result changed while stalled");

	// The MAC is only nonzero once the search has resolved.
	a_mac_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.search_state != arprr_pkg::PH_RESOLVED) |->
		(out_item.peer_mac == 48'd0))
		else $error("MAC reported without resolution");

	// A fresh result comes from an accepted item that passed the input and output registers.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching input item");

endmodule

bind arp_reply_resolver_core arprr_checker u_arprr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// ARP reply resolver testbench
// Drives start commands, frame bytes and timeout ticks into the resolver
// core, predicts every result item from an internal model of the search, and
// checks results in order while both sides idle and stall at random.
// ============================================================================

module tb_top;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	// Frame body left fully random, with no ARP fields patched in.
	localparam logic [3:0] FRAME_RANDOM = 4'hf;
	localparam int         QUIET_LIMIT  = 1000;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	arprr_pkg::in_item_t             in_item   = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	arprr_pkg::out_item_t            out_item;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [arprr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]                     cfg_data  = '0;

	// Register copies and search state as the block should hold them.
	logic [31:0] own_ip_q     = '0;
	logic [31:0] target_ip_q  = '0;
	logic [7:0]  tick_limit_q = arprr_pkg::LIMIT_RST;
	logic [7:0]  miss_limit_q = arprr_pkg::LIMIT_RST;
	logic [7:0]  hdr_copy [arprr_pkg::HEADER_BYTES];
	int unsigned hdr_fill     = 0;
	logic [7:0]  tick_count   = '0;
	logic [7:0]  miss_count   = '0;
	logic [1:0]  phase_now    = arprr_pkg::PH_SEARCH;
	logic [47:0] mac_now      = '0;
	arprr_pkg::out_item_t expected_results [$];
	arprr_pkg::out_item_t due_result;

	int         items_sent   = 0;
	int         results_made = 0;
	int         resolved_cnt = 0;
	int         gave_up_cnt  = 0;
	int         mismatches   = 0;
	int         quiet_cycles = 0;
	int         stall_left   = 0;
	logic [8:0] status_seen  = '0;
	bit         calm         = 1'b0;
	bit         gaps_on      = 1'b1;
	bit         stalls_on    = 1'b1;

	arp_reply_resolver_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] pair_at(input int off);
		return {hdr_copy[off], hdr_copy[off+1]};
	endfunction

	function automatic logic [31:0] quad_at(input int off);
		return {hdr_copy[off], hdr_copy[off+1], hdr_copy[off+2], hdr_copy[off+3]};
	endfunction

	function automatic logic [3:0] judge_frame();
		if (hdr_fill < arprr_pkg::HEADER_BYTES) return arprr_pkg::ST_SHORT;
		if (pair_at(arprr_pkg::OFF_ETYPE) != arprr_pkg::ETYPE_ARP)
			return arprr_pkg::ST_NOT_ARP;
		if (pair_at(arprr_pkg::OFF_HTYPE) != arprr_pkg::HTYPE_ETH)
			return arprr_pkg::ST_NOT_ETH;
		if (pair_at(arprr_pkg::OFF_PTYPE) != arprr_pkg::PTYPE_IPV4)
			return arprr_pkg::ST_NOT_IP;
		if (pair_at(arprr_pkg::OFF_OPER) != arprr_pkg::OPER_REPLY)
			return arprr_pkg::ST_NOT_REPLY;
		if (quad_at(arprr_pkg::OFF_SPA) != target_ip_q) return arprr_pkg::ST_SENDER_MISS;
		if (quad_at(arprr_pkg::OFF_TPA) != own_ip_q) return arprr_pkg::ST_TARGET_MISS;
		return arprr_pkg::ST_MATCH;
	endfunction

	// Advances the search state by one accepted item and queues its result, if it has one.
	task automatic predict_resolver(input arprr_pkg::in_item_t it);
		arprr_pkg::out_item_t r;
		logic [3:0] verdict;
		int nxt;
		verdict = arprr_pkg::ST_NO_FRAME;
		case (it.mode)
			arprr_pkg::MODE_START: begin
				tick_count = '0;
				miss_count = '0;
				mac_now    = '0;
				phase_now  = arprr_pkg::PH_SEARCH;
			end
			arprr_pkg::MODE_TICK: begin
				if (phase_now == arprr_pkg::PH_SEARCH) begin
					if (tick_count >= tick_limit_q) begin
						phase_now = arprr_pkg::PH_GAVE_TIMEOUT;
						gave_up_cnt++;
					end else begin
						tick_count++;
					end
				end
			end
			arprr_pkg::MODE_BYTE: begin
				if (hdr_fill < arprr_pkg::HEADER_BYTES) begin
					hdr_copy[hdr_fill] = it.data_byte;
					hdr_fill++;
				end
				if (!it.last) return;
				verdict  = judge_frame();
				hdr_fill = 0;
				if (phase_now == arprr_pkg::PH_SEARCH) begin
					if (verdict == arprr_pkg::ST_MATCH) begin
						mac_now = {quad_at(arprr_pkg::OFF_SHA), pair_at(arprr_pkg::OFF_SHA + 4)};
						phase_now = arprr_pkg::PH_RESOLVED;
						resolved_cnt++;
					end else begin
						nxt = miss_count + 1;
						if (nxt >= miss_limit_q) begin
							phase_now = arprr_pkg::PH_GAVE_FRAMES;
							gave_up_cnt++;
						end
						miss_count = (nxt > 255) ? 8'd255 : 8'(nxt);
					end
				end
			end
			default: return;
		endcase
		r.frame_status = verdict;
		r.search_state = phase_now;
		r.peer_mac     = mac_now;
		expected_results = {expected_results, r};
		results_made++;
		status_seen[verdict] = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("tb: mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_op(input logic [1:0] op, input logic [7:0] data, input logic last);
		arprr_pkg::in_item_t it;
		it.mode      = op;
		it.data_byte = data;
		it.last      = last;
		@(negedge clk);
		if (!calm && gaps_on && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		predict_resolver(it);
		if (op != MODE_UNUSED) items_sent++;
	endtask

	task automatic send_control(input logic [1:0] op);
		send_op(op, 8'($urandom), 1'($urandom));
	endtask

	task automatic send_frame(input int len, input logic [3:0] flaw, input bit mixed);
		logic [7:0] body [];
		int base;
		int span;
		body = new[(len < arprr_pkg::HEADER_BYTES) ? arprr_pkg::HEADER_BYTES : len];
		foreach (body[i]) body[i] = 8'($urandom);
		if (flaw != FRAME_RANDOM) begin
			{body[arprr_pkg::OFF_ETYPE], body[arprr_pkg::OFF_ETYPE+1]} = arprr_pkg::ETYPE_ARP;
			{body[arprr_pkg::OFF_HTYPE], body[arprr_pkg::OFF_HTYPE+1]} = arprr_pkg::HTYPE_ETH;
			{body[arprr_pkg::OFF_PTYPE], body[arprr_pkg::OFF_PTYPE+1]} = arprr_pkg::PTYPE_IPV4;
			{body[arprr_pkg::OFF_OPER], body[arprr_pkg::OFF_OPER+1]}   = arprr_pkg::OPER_REPLY;
			{body[arprr_pkg::OFF_SPA], body[arprr_pkg::OFF_SPA+1], body[arprr_pkg::OFF_SPA+2],
				body[arprr_pkg::OFF_SPA+3]} = target_ip_q;
			{body[arprr_pkg::OFF_TPA], body[arprr_pkg::OFF_TPA+1], body[arprr_pkg::OFF_TPA+2],
				body[arprr_pkg::OFF_TPA+3]} = own_ip_q;
		end
		base = -1;
		span = 2;
		case (flaw)
			arprr_pkg::ST_NOT_ARP:     base = arprr_pkg::OFF_ETYPE;
			arprr_pkg::ST_NOT_ETH:     base = arprr_pkg::OFF_HTYPE;
			arprr_pkg::ST_NOT_IP:      base = arprr_pkg::OFF_PTYPE;
			arprr_pkg::ST_NOT_REPLY:   base = arprr_pkg::OFF_OPER;
			arprr_pkg::ST_SENDER_MISS: begin
				base = arprr_pkg::OFF_SPA;
				span = 4;
			end
			arprr_pkg::ST_TARGET_MISS: begin
				base = arprr_pkg::OFF_TPA;
				span = 4;
			end
			default: ;
		endcase
		// A nonzero XOR guarantees the chosen field no longer matches.
		if (base >= 0) body[base + $urandom_range(0, span - 1)] ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < len; i++) begin
			if (mixed && $urandom_range(0, 29) == 0) begin
				case ($urandom_range(0, 2))
					0: send_control(arprr_pkg::MODE_START);
					1: send_control(arprr_pkg::MODE_TICK);
					default: send_control(MODE_UNUSED);
				endcase
			end
			send_op(arprr_pkg::MODE_BYTE, body[i], i == len - 1);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [arprr_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			arprr_pkg::CFG_OWN_IP:        own_ip_q     = data;
			arprr_pkg::CFG_TARGET_IP:     target_ip_q  = data;
			arprr_pkg::CFG_TIMEOUT_LIMIT: tick_limit_q = data[7:0];
			arprr_pkg::CFG_FRAME_LIMIT:   miss_limit_q = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [31:0] own, input logic [31:0] tgt,
			input logic [7:0] tlim, input logic [7:0] flim);
		drain_results();
		// Bytes without last leave no result, so give the pipeline time to empty.
		repeat (4) @(posedge clk);
		write_reg(arprr_pkg::CFG_OWN_IP, own);
		write_reg(arprr_pkg::CFG_TARGET_IP, tgt);
		write_reg(arprr_pkg::CFG_TIMEOUT_LIMIT, {24'd0, tlim});
		write_reg(arprr_pkg::CFG_FRAME_LIMIT, {24'd0, flim});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [3:0] pick_flaw();
		case ($urandom_range(0, 8))
			0, 1: return arprr_pkg::ST_MATCH;
			2: return arprr_pkg::ST_SHORT;
			3: return arprr_pkg::ST_NOT_ARP;
			4: return arprr_pkg::ST_NOT_ETH;
			5: return arprr_pkg::ST_NOT_IP;
			6: return arprr_pkg::ST_NOT_REPLY;
			7: return arprr_pkg::ST_SENDER_MISS;
			default: return arprr_pkg::ST_TARGET_MISS;
		endcase
	endfunction

	// Well-formed replies, most with one field broken or cut short at random,
	// mixed with starts, ticks, unused modes, noise frames and occasional full drains.
	task automatic run_search(input int n_items);
		int goal;
		int first_result;
		int pick;
		int len;
		logic [3:0] flaw;
		goal         = items_sent + n_items;
		first_result = results_made;
		send_control(arprr_pkg::MODE_START);
		while (items_sent < goal || results_made - first_result < 12) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				flaw = pick_flaw();
				if (flaw == arprr_pkg::ST_SHORT) begin
					len = $urandom_range(1, arprr_pkg::HEADER_BYTES - 1);
				end else if ($urandom_range(0, 9) == 0) begin
					len = $urandom_range(arprr_pkg::HEADER_BYTES + 1, 90);
				end else begin
					len = $urandom_range(arprr_pkg::HEADER_BYTES, arprr_pkg::HEADER_BYTES + 2);
				end
				send_frame(len, flaw, 1'b1);
			end else if (pick < 50) begin
				send_frame($urandom_range(1, 50), FRAME_RANDOM, 1'b1);
			end else if (pick < 62) begin
				send_control(arprr_pkg::MODE_START);
			end else if (pick < 82) begin
				send_control(arprr_pkg::MODE_TICK);
			end else if (pick < 90) begin
				send_control(MODE_UNUSED);
			end else if (pick < 94) begin
				drain_results();
			end else begin
				send_frame($urandom_range(1, 3), arprr_pkg::ST_SHORT, 1'b0);
			end
		end
	endtask

	task automatic test_directed_checks();
		send_op(arprr_pkg::MODE_START, 8'h00, 1'b0);
		send_op(arprr_pkg::MODE_TICK, 8'hff, 1'b1);
		send_op(MODE_UNUSED, 8'hff, 1'b1);
		send_op(arprr_pkg::MODE_BYTE, 8'hff, 1'b1);
		send_op(arprr_pkg::MODE_BYTE, 8'h00, 1'b1);
		// A tick, a start and an unused mode inside a frame leave it intact.
		send_op(arprr_pkg::MODE_BYTE, 8'ha5, 1'b0);
		send_op(arprr_pkg::MODE_TICK, 8'h00, 1'b0);
		send_op(arprr_pkg::MODE_START, 8'hff, 1'b1);
		send_op(MODE_UNUSED, 8'h00, 1'b0);
		send_op(arprr_pkg::MODE_BYTE, 8'h5a, 1'b1);
		send_op(arprr_pkg::MODE_TICK, 8'h3c, 1'b0);
	endtask

	task automatic test_default_search();
		run_search(200);
	endtask

	task automatic test_all_ones_tight_limits();
		set_registers(32'hffff_ffff, 32'hffff_ffff, 8'd1, 8'd1);
		run_search(200);
	endtask

	task automatic test_mixed_limits();
		set_registers(32'h0, $urandom, 8'($urandom_range(2, 6)), 8'($urandom_range(2, 6)));
		run_search(200);
	endtask

	task automatic test_random_limits();
		set_registers($urandom, $urandom, 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255)));
		run_search(200);
	endtask

	// Counts both limits all the way up at 255, then down at 1.
	task automatic test_limit_extremes();
		set_registers(own_ip_q, target_ip_q, 8'd255, 8'd255);
		send_control(arprr_pkg::MODE_START);
		repeat (257) send_control(arprr_pkg::MODE_TICK);
		send_control(arprr_pkg::MODE_START);
		repeat (256) send_op(arprr_pkg::MODE_BYTE, 8'($urandom), 1'b1);
		set_registers(own_ip_q, target_ip_q, 8'd1, 8'd1);
		send_control(arprr_pkg::MODE_START);
		repeat (3) send_control(arprr_pkg::MODE_TICK);
		send_control(arprr_pkg::MODE_START);
		repeat (2) send_op(arprr_pkg::MODE_BYTE, 8'($urandom), 1'b1);
	endtask

	task automatic test_quiet_tail();
		calm = 1'b1;
		set_registers($urandom, $urandom, 8'($urandom_range(3, 10)),
			8'($urandom_range(3, 10)));
		run_search(120);
	endtask

	// Receiver: stalls in bursts, with stretches where stalling is off.
	always @(negedge clk) begin
		if (!calm && stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!calm && stalls_on && $urandom_range(0, 11) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 18) - 1;
		end else begin
			out_stall <= 1'b0;
		end
		if ($urandom_range(0, 199) == 0) stalls_on = !stalls_on;
		if ($urandom_range(0, 199) == 0) gaps_on = !gaps_on;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing expected", 64'(out_item), 64'd0);
			end else begin
				due_result = expected_results.pop_front();
				if (out_item.frame_status != due_result.frame_status)
					report_mismatch("frame_status", 64'(out_item.frame_status),
						64'(due_result.frame_status));
				if (out_item.search_state != due_result.search_state)
					report_mismatch("search_state", 64'(out_item.search_state),
						64'(due_result.search_state));
				if (out_item.peer_mac != due_result.peer_mac)
					report_mismatch("peer_mac", 64'(out_item.peer_mac),
						64'(due_result.peer_mac));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_checks();
		test_default_search();
		test_all_ones_tight_limits();
		test_mixed_limits();
		test_random_limits();
		test_limit_extremes();
		test_quiet_tail();
		drain_results();
		repeat (8) @(posedge clk);
		$display("tb: %0d items driven, %0d results checked, %0d searches resolved, %0d given up",
			items_sent, results_made, resolved_cnt, gave_up_cnt);
		$display("tb: frame status codes reached (one bit per code, no frame highest): %b",
			status_seen);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
